// ----- src/dbf_pkg.sv -----
// Package for the depth bilateral filter: shared types, register indexes and constants.
// No dependencies; dbf_div, dbf_datapath, dbf_ctrl and the top level import it.
`default_nettype none
package dbf_pkg;
    localparam int POS_W = 12;
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 24;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] TENTH_Q16 = 16'd6554;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PRESERVE_EDGES = 3'd2;
    localparam logic [2:0] REG_SPATIAL_COEF = 3'd3;
    localparam logic [2:0] REG_RANGE_COEF = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic        preserve_edges;
        logic [15:0] spatial_coef;
        logic [15:0] range_coef;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic rd_nb;
        logic lat_center;
        logic lat_nb;
        logic ld_sarg;
        logic exp1;
        logic exp2_s;
        logic exp2_r;
        logic q2;
        logic rm_lo;
        logic rm_hi;
        logic ld_rarg;
        logic edge_scale;
        logic wt;
        logic acc;
        logic nb_step;
        logic fdiv_start;
        logic fdiv_ld;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic emit_needed;
        logic pass_center;
        logic nb_skip;
        logic n_invalid;
        logic div_busy;
        logic nb_last;
        logic out_free;
    } sts_t;
endpackage
`default_nettype wire

// ----- src/dbf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module dbf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8197
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/dbf_div.sv -----
// Restoring divider producing one quotient bit per cycle.
// Depends on dbf_pkg for the operand widths.
`default_nettype none
module dbf_div
    import dbf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [DIV_DW-1:0] divisor,
    output logic                   busy,
    output logic      [DIV_NW-1:0] quotient
);
    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_NW-1:0] dq_reg, dq_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_DW:0]   trial;

    assign trial = {rem_reg, dq_reg[DIV_NW-1]};

    always_comb begin
        cnt_next = cnt_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = CNT_W'(DIV_NW);
            dq_next = dividend;
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIV_DW'(trial - {1'b0, dvs_reg});
                dq_next = {dq_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_DW-1:0];
                dq_next = {dq_reg[DIV_NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy = cnt_reg != '0;
    assign quotient = dq_reg;
endmodule
`default_nettype wire

// ----- src/dbf_datapath.sv -----
// Datapath of the depth bilateral filter: line store, position counters, weight arithmetic,
// accumulators and output register. Depends on dbf_pkg, dbf_ram and dbf_div.
`default_nettype none
module dbf_datapath
    import dbf_pkg::*;
#(
    parameter int RADIUS = 2,
    parameter int MAX_WIDTH = 2048,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic [15:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);
    localparam int STORE_DEPTH = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int BK_W = PTR_W + 2;
    localparam int EXP_AW = $clog2(EXP_TABLE_DEPTH);

    function automatic logic [16*EXP_TABLE_DEPTH-1:0] build_rom();
        logic [63:0] u;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] v;
        logic [16*EXP_TABLE_DEPTH-1:0] r;
        r = '0;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            u = (64'(k) * LN2_Q32) / EXP_TABLE_DEPTH;
            sum = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int i = 1; i <= 20; i++) begin
                term = ((term * u) >> 32) / 64'(i);
                if ((i % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd32768) >> 16;
            r[k*16 +: 16] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        return r;
    endfunction

    localparam logic [16*EXP_TABLE_DEPTH-1:0] ROM_BITS = build_rom();
    localparam logic signed [3:0] RPOS = 4'(RADIUS);

    logic [PTR_W-1:0]  wr_ptr_reg, pend_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              op_reg;
    logic [POS_W-1:0]  col_reg, row_reg;
    logic [16:0]       cword_reg;
    logic [15:0]       res_reg, n_reg;
    logic signed [3:0] dx_reg, dy_reg;
    logic signed [BK_W-1:0] off_reg;
    logic [19:0]       exp_arg_reg;
    logic              exp_zero_reg;
    logic [20:0]       y_reg;
    logic [15:0]       sw_reg, rw_reg, wt_reg;
    logic [45:0]       q2_reg;
    logic [37:0]       plo_reg;
    logic [39:0]       phi_reg;
    logic [23:0]       wsum_reg;
    logic [39:0]       vsum_reg;
    logic              mv_reg;
    logic [15:0]       md_reg;
    logic              ml_reg, mu_reg;

    logic [POS_W-1:0]  eff_w, eff_h;
    logic [PTR_W:0]    delay;
    logic [16:0]       rdata;
    logic [PTR_W-1:0]  raddr, ci, nidx;
    logic signed [BK_W-1:0] back, tci, tnb, tci_w, tnb_w;
    logic [15:0]       c_val, n_in, diff;
    logic              row_end, frame_end;
    logic signed [7:0] dx2, dy2;
    logic [5:0]        d2;
    logic [21:0]       sprod;
    logic [29:0]       sarg;
    logic [36:0]       yprod;
    logic [EXP_AW-1:0] fi;
    logic [15:0]       romv, e_val;
    logic [22:0]       q23;
    logic [61:0]       rsum;
    logic [37:0]       rarg;
    logic [31:0]       escaled, wprod;
    logic [30:0]       nw;
    logic              div_start, div_busy;
    logic [DIV_NW-1:0] div_dividend, quo;
    logic [DIV_DW-1:0] div_divisor;

    assign eff_w = (cfg.frame_width == '0) ? POS_W'(1) :
                   ((32'(cfg.frame_width) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : cfg.frame_width);
    assign eff_h = (cfg.frame_height == '0) ? POS_W'(1) : cfg.frame_height;
    assign delay = (PTR_W+1)'(RADIUS * 32'(eff_w) + RADIUS);

    assign tci = $signed(BK_W'(wr_ptr_reg)) - $signed(BK_W'(pend_reg));
    assign tci_w = (tci < 0) ? tci + $signed(BK_W'(STORE_DEPTH)) : tci;
    assign ci = tci_w[PTR_W-1:0];
    assign back = $signed(BK_W'(pend_reg)) - $signed(BK_W'(1)) - off_reg;
    assign tnb = $signed(BK_W'(wr_ptr_reg)) - $signed(BK_W'(1)) - back;
    assign tnb_w = (tnb < 0) ? tnb + $signed(BK_W'(STORE_DEPTH)) : tnb;
    assign nidx = tnb_w[PTR_W-1:0];
    assign raddr = cmd.rd_nb ? nidx : ci;

    dbf_ram #(.WIDTH(17), .DEPTH(STORE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (cmd.accept && (s_tuser[0] == OP_PIXEL)),
        .waddr (wr_ptr_reg),
        .wdata ({s_tuser[1], s_tdata}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign c_val = cword_reg[15:0];
    assign n_in = rdata[15:0];
    assign diff = (n_in > c_val) ? n_in - c_val : c_val - n_in;
    assign div_start = (cmd.lat_nb && !sts.n_invalid) || cmd.fdiv_start;
    assign div_dividend = cmd.fdiv_start ? vsum_reg + DIV_NW'(wsum_reg >> 1)
                                         : DIV_NW'({diff, 16'b0});
    assign div_divisor = cmd.fdiv_start ? wsum_reg : DIV_DW'(c_val);

    dbf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign row_end = 32'(col_reg) + 1 >= 32'(eff_w);
    assign frame_end = row_end && (32'(row_reg) + 1 >= 32'(eff_h));

    assign dx2 = 8'(dx_reg) * 8'(dx_reg);
    assign dy2 = 8'(dy_reg) * 8'(dy_reg);
    assign d2 = 6'(dx2 + dy2);
    assign sprod = 22'(d2) * 22'(cfg.spatial_coef);
    assign sarg = {sprod, 8'b0};
    assign yprod = 37'(exp_arg_reg) * 37'(LOG2E_Q16);
    assign fi = EXP_AW'((32'(y_reg[15:0]) * EXP_TABLE_DEPTH) >> 16);
    assign romv = ROM_BITS[{fi, 4'b0} +: 16];
    assign e_val = exp_zero_reg ? 16'd0 : (romv >> y_reg[20:16]);
    assign q23 = (|quo[DIV_NW-1:23]) ? 23'h7FFFFF : quo[22:0];
    assign rsum = {phi_reg, 22'b0} + 62'(plo_reg);
    assign rarg = rsum[61:24];
    assign escaled = 32'(rw_reg) * 32'(TENTH_Q16);
    assign wprod = 32'(sw_reg) * 32'(rw_reg) + 32'd32768;
    assign nw = 31'(n_reg) * 31'(wt_reg);

    assign sts.emit_needed = (op_reg == OP_DRAIN) ? (pend_reg != '0) : ({1'b0, pend_reg} > delay);
    assign sts.pass_center = (rdata[15:0] == 16'd0) || rdata[15] ||
                             (32'(row_reg) < RADIUS) || (32'(col_reg) < RADIUS) ||
                             (32'(row_reg) + RADIUS >= 32'(eff_h)) ||
                             (32'(col_reg) + RADIUS >= 32'(eff_w));
    assign sts.nb_skip = ((dx_reg == 4'sd0) && (dy_reg == 4'sd0)) || (back < 0) ||
                         (back >= $signed(BK_W'(fill_reg)));
    assign sts.n_invalid = (n_in == 16'd0) || n_in[15];
    assign sts.div_busy = div_busy;
    assign sts.nb_last = (dx_reg == RPOS) && (dy_reg == RPOS);
    assign sts.out_free = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            fill_reg <= '0;
            pend_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (cmd.accept && (s_tuser[0] == OP_PIXEL)) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == STORE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
                if (32'(fill_reg) < STORE_DEPTH) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                pend_reg <= pend_reg + 1'b1;
            end
            if (cmd.out_load) begin
                pend_reg <= pend_reg - 1'b1;
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= (32'(row_reg) + 1 >= 32'(eff_h)) ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= s_tuser[0];
        end
        if (cmd.lat_center) begin
            cword_reg <= rdata;
            res_reg <= rdata[15:0];
            dx_reg <= -RPOS;
            dy_reg <= -RPOS;
            off_reg <= -$signed(BK_W'(RADIUS * 32'(eff_w) + RADIUS));
            wsum_reg <= 24'd65536;
            vsum_reg <= {8'b0, rdata[15:0], 16'b0};
        end
        if (cmd.lat_nb) begin
            n_reg <= n_in;
        end
        if (cmd.ld_sarg) begin
            exp_arg_reg <= sarg[19:0];
            exp_zero_reg <= |sarg[29:20];
        end
        if (cmd.ld_rarg) begin
            exp_arg_reg <= rarg[19:0];
            exp_zero_reg <= |rarg[37:20];
        end
        if (cmd.exp1) begin
            y_reg <= yprod[36:16];
        end
        if (cmd.exp2_s) begin
            sw_reg <= e_val;
        end
        if (cmd.exp2_r) begin
            rw_reg <= e_val;
        end
        if (cmd.edge_scale && cfg.preserve_edges && cword_reg[16]) begin
            rw_reg <= escaled[31:16];
        end
        if (cmd.q2) begin
            q2_reg <= 46'(q23) * 46'(q23);
        end
        if (cmd.rm_lo) begin
            plo_reg <= 38'(q2_reg[21:0]) * 38'(cfg.range_coef);
        end
        if (cmd.rm_hi) begin
            phi_reg <= 40'(q2_reg[45:22]) * 40'(cfg.range_coef);
        end
        if (cmd.wt) begin
            wt_reg <= wprod[31:16];
        end
        if (cmd.acc) begin
            wsum_reg <= wsum_reg + 24'(wt_reg);
            vsum_reg <= vsum_reg + 40'(nw);
        end
        if (cmd.nb_step) begin
            if (dx_reg == RPOS) begin
                dx_reg <= -RPOS;
                dy_reg <= dy_reg + 4'sd1;
                off_reg <= off_reg + $signed(BK_W'(eff_w)) - $signed(BK_W'(2 * RADIUS));
            end else begin
                dx_reg <= dx_reg + 4'sd1;
                off_reg <= off_reg + $signed(BK_W'(1));
            end
        end
        if (cmd.fdiv_ld) begin
            res_reg <= quo[15:0];
        end
        if (cmd.out_load) begin
            md_reg <= res_reg;
            ml_reg <= row_end;
            mu_reg <= frame_end;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;
    assign m_tlast = ml_reg;
    assign m_tuser = mu_reg;
endmodule
`default_nettype wire

// ----- src/dbf_ctrl.sv -----
// Controller state machine of the depth bilateral filter, sequencing the datapath.
// Depends on dbf_pkg for the command and status structs.
`default_nettype none
module dbf_ctrl
    import dbf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_DECIDE = 20'h00002,
        ST_CLAT   = 20'h00004,
        ST_NADDR  = 20'h00008,
        ST_NLAT   = 20'h00010,
        ST_SARG   = 20'h00020,
        ST_EXP1   = 20'h00040,
        ST_EXP2   = 20'h00080,
        ST_DIVW   = 20'h00100,
        ST_Q2     = 20'h00200,
        ST_RMLO   = 20'h00400,
        ST_RMHI   = 20'h00800,
        ST_RARG   = 20'h01000,
        ST_EDGE   = 20'h02000,
        ST_WT     = 20'h04000,
        ST_ACC    = 20'h08000,
        ST_NEXT   = 20'h10000,
        ST_FSTART = 20'h20000,
        ST_FDIV   = 20'h40000,
        ST_FINISH = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = sts.emit_needed ? ST_CLAT : ST_IDLE;
            ST_CLAT:   state_next = sts.pass_center ? ST_FINISH : ST_NADDR;
            ST_NADDR:  state_next = sts.nb_skip ? ST_NEXT : ST_NLAT;
            ST_NLAT:   state_next = sts.n_invalid ? ST_NEXT : ST_SARG;
            ST_SARG: begin
                state_next = ST_EXP1;
                phase_next = 1'b0;
            end
            ST_EXP1:   state_next = ST_EXP2;
            ST_EXP2:   state_next = phase_reg ? ST_EDGE : ST_DIVW;
            ST_DIVW:   state_next = sts.div_busy ? ST_DIVW : ST_Q2;
            ST_Q2:     state_next = ST_RMLO;
            ST_RMLO:   state_next = ST_RMHI;
            ST_RMHI:   state_next = ST_RARG;
            ST_RARG: begin
                state_next = ST_EXP1;
                phase_next = 1'b1;
            end
            ST_EDGE:   state_next = ST_WT;
            ST_WT:     state_next = ST_ACC;
            ST_ACC:    state_next = ST_NEXT;
            ST_NEXT:   state_next = sts.nb_last ? ST_FSTART : ST_NADDR;
            ST_FSTART: state_next = ST_FDIV;
            ST_FDIV:   state_next = sts.div_busy ? ST_FDIV : ST_FINISH;
            ST_FINISH: state_next = sts.out_free ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd = '0;
        cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
        cmd.rd_nb = (state_reg == ST_NADDR);
        cmd.lat_center = (state_reg == ST_CLAT);
        cmd.lat_nb = (state_reg == ST_NLAT);
        cmd.ld_sarg = (state_reg == ST_SARG);
        cmd.exp1 = (state_reg == ST_EXP1);
        cmd.exp2_s = (state_reg == ST_EXP2) && !phase_reg;
        cmd.exp2_r = (state_reg == ST_EXP2) && phase_reg;
        cmd.q2 = (state_reg == ST_Q2);
        cmd.rm_lo = (state_reg == ST_RMLO);
        cmd.rm_hi = (state_reg == ST_RMHI);
        cmd.ld_rarg = (state_reg == ST_RARG);
        cmd.edge_scale = (state_reg == ST_EDGE);
        cmd.wt = (state_reg == ST_WT);
        cmd.acc = (state_reg == ST_ACC);
        cmd.nb_step = (state_reg == ST_NEXT);
        cmd.fdiv_start = (state_reg == ST_FSTART);
        cmd.fdiv_ld = (state_reg == ST_FDIV) && !sts.div_busy;
        cmd.out_load = (state_reg == ST_FINISH) && sts.out_free;
    end
endmodule
`default_nettype wire

// ----- src/depth_bilateral_filter.sv -----
// Depth bilateral filter top level: configuration registers and the controller/datapath pair.
// Depends on dbf_pkg, dbf_ctrl and dbf_datapath.
//
// The block filters a raster stream of Q12.4 depth pixels with a (2*RADIUS+1)-square bilateral
// window and emits each pixel RADIUS*W+RADIUS pixels after it was received; drain transactions
// push out the remaining pixels one per transaction. One transaction is handled at a time.
// A filtered pixel is held longer while the output register is full; most of its time goes to
// the bit-serial divider forming the relative difference of each neighbor and the final
// normalization. Results wait in an output register, and the line store needs no clearing
// after reset.
`default_nettype none
module depth_bilateral_filter
    import dbf_pkg::*;
#(
    parameter int RADIUS = 2,
    parameter int MAX_WIDTH = 2048,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // depth_in
    input  wire logic [1:0]  s_tuser,   // op, edge_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // depth_out
    output logic             m_tlast,
    output logic             m_tuser,   // frame_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width <= 12'd640;
            cfg_reg.frame_height <= 12'd480;
            cfg_reg.preserve_edges <= 1'b1;
            cfg_reg.spatial_coef <= 16'd128;
            cfg_reg.range_coef <= 16'd12800;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_FRAME_WIDTH:    cfg_reg.frame_width <= pwdata[11:0];
                REG_FRAME_HEIGHT:   cfg_reg.frame_height <= pwdata[11:0];
                REG_PRESERVE_EDGES: cfg_reg.preserve_edges <= pwdata[0];
                REG_SPATIAL_COEF:   cfg_reg.spatial_coef <= pwdata[15:0];
                REG_RANGE_COEF:     cfg_reg.range_coef <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_FRAME_WIDTH:    prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:   prdata = 32'(cfg_reg.frame_height);
            REG_PRESERVE_EDGES: prdata = 32'(cfg_reg.preserve_edges);
            REG_SPATIAL_COEF:   prdata = 32'(cfg_reg.spatial_coef);
            REG_RANGE_COEF:     prdata = 32'(cfg_reg.range_coef);
            default:            prdata = 32'd0;
        endcase
    end

    dbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dbf_datapath #(
        .RADIUS          (RADIUS),
        .MAX_WIDTH       (MAX_WIDTH),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

// ----- src/dbf_checker.sv -----
// Port-level checker for the depth bilateral filter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module dbf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Output transaction changed while stalled.");

    a_frame_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("Frame end without row end.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while a transaction is in progress.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid right after reset.");
endmodule

bind depth_bilateral_filter dbf_checker u_dbf_checker (.*);
`default_nettype wire
